### design/sorted_table_binary_search_assert.svh
// Assertion macros for the sorted table search block and its checker
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define STBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/stbs_pkg.sv
// Package: shared constants, codes and command/status types of the table search
`default_nettype none
package stbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int BND_W       = ADDR_W + 1;

   localparam int DATA_W      = 32;
   localparam int ENTRY_IDX_W = 10;
   localparam int RANGE_W     = 11;
   localparam int MODE_W      = 2;
   localparam int MATCH_W     = 10;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   localparam logic [MODE_W-1:0] MODE_EXACT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;

   localparam logic [1:0] RES_MISS = 2'd0;
   localparam logic [1:0] RES_MID  = 2'd1;
   localparam logic [1:0] RES_TAIL = 2'd2;

   typedef struct packed {
      logic       write;
      logic       load;
      logic       read;
      logic       step;
      logic       res_set;
      logic [1:0] res_op;
      logic       publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip;
      logic empty;
      logic is_exact;
      logic exact_hit;
      logic tail_ok;
   } dp_stat_type;

endpackage
`default_nettype wire

### design/stbs_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/stbs_ctrl.sv
// Controller: sequences table writes, bisection probes, tail check and result hand-off
`default_nettype none
module stbs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_action,
   output logic                       req_ready,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   input  wire stbs_pkg::dp_stat_type stat,
   output stbs_pkg::ctrl_cmd_type     cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOP = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_TAIL = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == stbs_pkg::ACT_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = S_LOOP;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         S_LOOP: begin
            if (stat.skip) begin
               cmd.res_set = 1'b1;
               cmd.res_op  = stbs_pkg::RES_MISS;
               state_in    = S_FIN;
            end else if (!stat.empty) begin
               cmd.read = 1'b1;
               state_in = S_CMP;
            end else if (stat.is_exact || !stat.tail_ok) begin
               cmd.res_set = 1'b1;
               cmd.res_op  = stbs_pkg::RES_MISS;
               state_in    = S_FIN;
            end else begin
               cmd.read = 1'b1;
               state_in = S_TAIL;
            end
         end
         S_CMP: begin
            if (stat.exact_hit) begin
               cmd.res_set = 1'b1;
               cmd.res_op  = stbs_pkg::RES_MID;
               state_in    = S_FIN;
            end else begin
               cmd.step = 1'b1;
               state_in = S_LOOP;
            end
         end
         S_TAIL: begin
            cmd.res_set = 1'b1;
            cmd.res_op  = stbs_pkg::RES_TAIL;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### design/stbs_dp.sv
// Datapath: table RAM, search bounds, probe compare and result registers
`default_nettype none
module stbs_dp (
   input  wire logic                                     clock,
   input  wire stbs_pkg::ctrl_cmd_type                   cmd,
   output stbs_pkg::dp_stat_type                         stat,
   input  wire logic        [stbs_pkg::ENTRY_IDX_W-1:0]  req_entry_index,
   input  wire logic signed [stbs_pkg::DATA_W-1:0]       req_entry_value,
   input  wire logic        [stbs_pkg::MODE_W-1:0]       req_search_mode,
   input  wire logic        [stbs_pkg::RANGE_W-1:0]      req_range_start,
   input  wire logic        [stbs_pkg::RANGE_W-1:0]      req_range_end,
   input  wire logic signed [stbs_pkg::DATA_W-1:0]       req_search_key,
   output logic                                          rsp_found,
   output logic             [stbs_pkg::MATCH_W-1:0]      rsp_match_index
);

   localparam int BW = stbs_pkg::BND_W;
   localparam int AW = stbs_pkg::ADDR_W;

   logic        [BW-1:0]                  lo_ff, lo_in, hi_ff, hi_in;
   logic        [BW-1:0]                  start_ff, end_ff;
   logic        [stbs_pkg::MODE_W-1:0]    mode_ff;
   logic signed [stbs_pkg::DATA_W-1:0]    key_ff;
   logic                                  skip_ff;
   logic                                  pend_found_ff, pend_found_in;
   logic        [stbs_pkg::MATCH_W-1:0]   pend_idx_ff, pend_idx_in;
   logic                                  rsp_found_ff;
   logic        [stbs_pkg::MATCH_W-1:0]   rsp_idx_ff;

   logic        [31:0]                    end_wide, start_wide, depth_wide;
   logic        [BW-1:0]                  end_sat;
   logic        [BW:0]                    mid_sum;
   logic        [BW-1:0]                  mid, tail;
   logic        [31:0]                    mid_wide, tail_wide;
   logic signed [stbs_pkg::DATA_W-1:0]    rd_data;
   logic        [AW-1:0]                  rd_addr;
   logic                                  wr_en;
   logic                                  is_lt, is_eq;

   assign depth_wide = 32'(stbs_pkg::TABLE_DEPTH);
   assign end_wide   = 32'(req_range_end);
   assign start_wide = 32'(req_range_start);
   assign end_sat    = (end_wide > depth_wide) ? BW'(depth_wide) : BW'(end_wide);

   assign wr_en = cmd.write && (32'(req_entry_index) < depth_wide);

   // All modes bisect the half-open range [lo, hi); exact mode rounds the midpoint toward lo
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff}
                    - (BW+1)'(mode_ff == stbs_pkg::MODE_EXACT);
   assign mid     = mid_sum[BW:1];
   assign tail    = (mode_ff == stbs_pkg::MODE_LEFT) ? lo_ff : lo_ff - BW'(1);
   assign rd_addr = (lo_ff >= hi_ff) ? tail[AW-1:0] : mid[AW-1:0];

   assign mid_wide  = 32'(mid);
   assign tail_wide = 32'(tail);

   stbs_ram #(
      .WIDTH (stbs_pkg::DATA_W),
      .DEPTH (stbs_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index[AW-1:0]),
      .wr_data (req_entry_value),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign is_lt = (rd_data < key_ff);
   assign is_eq = (rd_data == key_ff);

   always_comb begin
      stat.skip      = skip_ff;
      stat.empty     = (lo_ff >= hi_ff);
      stat.is_exact  = (mode_ff == stbs_pkg::MODE_EXACT);
      stat.exact_hit = (mode_ff == stbs_pkg::MODE_EXACT) && is_eq;
      stat.tail_ok   = (mode_ff == stbs_pkg::MODE_LEFT) ? (lo_ff != end_ff)
                                                       : (lo_ff != start_ff);
   end

   // Load the bounds on a new search and narrow them after a probe
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.load) begin
         lo_in = BW'(start_wide);
         hi_in = end_sat;
      end else if (cmd.step) begin
         case (mode_ff)
            stbs_pkg::MODE_RIGHT: begin
               if (is_lt || is_eq) begin
                  lo_in = mid + BW'(1);
               end else begin
                  hi_in = mid;
               end
            end
            default: begin
               if (is_lt) begin
                  lo_in = mid + BW'(1);
               end else begin
                  hi_in = mid;
               end
            end
         endcase
      end
   end

   always_comb begin
      pend_found_in = pend_found_ff;
      pend_idx_in   = pend_idx_ff;
      if (cmd.res_set) begin
         case (cmd.res_op)
            stbs_pkg::RES_MID: begin
               pend_found_in = 1'b1;
               pend_idx_in   = mid_wide[stbs_pkg::MATCH_W-1:0];
            end
            stbs_pkg::RES_TAIL: begin
               pend_found_in = is_eq;
               pend_idx_in   = is_eq ? tail_wide[stbs_pkg::MATCH_W-1:0] : '0;
            end
            default: begin
               pend_found_in = 1'b0;
               pend_idx_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      pend_found_ff <= pend_found_in;
      pend_idx_ff   <= pend_idx_in;
      if (cmd.load) begin
         start_ff <= BW'(start_wide);
         end_ff   <= end_sat;
         mode_ff  <= req_search_mode;
         key_ff   <= req_search_key;
         skip_ff  <= (start_wide >= 32'(end_sat))
                     || !(req_search_mode inside {stbs_pkg::MODE_EXACT, stbs_pkg::MODE_LEFT,
                                                 stbs_pkg::MODE_RIGHT});
      end
      if (cmd.publish) begin
         rsp_found_ff <= pend_found_ff;
         rsp_idx_ff   <= pend_idx_ff;
      end
   end

   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_idx_ff;

endmodule
`default_nettype wire

### design/sorted_table_binary_search.sv
// Top level: sorted table with exact, leftmost and rightmost binary search
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  action, entry index/value, mode, range, key
//   rsp      out        rsp_valid / rsp_ready  found, match_index
//
// A write transaction is taken while the sequencer is idle and gives no response.
// A search transaction runs P bisection probes after acceptance (at most 11 for
// 1024 entries): each probe issues the registered RAM read and then the compare,
// followed by the final decision, the leftmost/rightmost tail read and the
// hand-off into the response register. An exact hit stops after its probe, a
// miss skips the tail read, and an empty range or the spare mode goes straight
// to the hand-off.
// reset is synchronous and clears only control state; table contents stay
// undefined until written. The response register lets a new transaction enter
// while a result waits; a search finishing then holds until rsp_ready frees it.
`default_nettype none
module sorted_table_binary_search (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic                                     req_action,
   input  wire logic        [stbs_pkg::ENTRY_IDX_W-1:0]  req_entry_index,
   input  wire logic signed [stbs_pkg::DATA_W-1:0]       req_entry_value,
   input  wire logic        [stbs_pkg::MODE_W-1:0]       req_search_mode,
   input  wire logic        [stbs_pkg::RANGE_W-1:0]      req_range_start,
   input  wire logic        [stbs_pkg::RANGE_W-1:0]      req_range_end,
   input  wire logic signed [stbs_pkg::DATA_W-1:0]       req_search_key,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic                                          rsp_found,
   output logic             [stbs_pkg::MATCH_W-1:0]      rsp_match_index
);

   // Command and status between the sequencer and the datapath
   stbs_pkg::ctrl_cmd_type cmd;
   stbs_pkg::dp_stat_type  stat;

   // Sequencer: accept, probe loop, tail check, hand-off
   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath: table memory, bounds, compare and response payload
   stbs_dp u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .stat            (stat),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_mode (req_search_mode),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_search_key  (req_search_key),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index)
   );

endmodule
`default_nettype wire

### design/stbs_checker.sv
// Checker on the top-level ports of the table search, with its bind
`default_nettype none
`include "sorted_table_binary_search_assert.svh"
module stbs_checker (
   input wire logic                                     clock,
   input wire logic                                     reset,
   input wire logic                                     req_valid,
   input wire logic                                     req_ready,
   input wire logic                                     req_action,
   input wire logic                                     rsp_valid,
   input wire logic                                     rsp_ready,
   input wire logic                                     rsp_found,
   input wire logic        [stbs_pkg::MATCH_W-1:0]      rsp_match_index
);

   logic req_fire, rsp_stall;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   `STBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_found) && $stable(rsp_match_index),
      "stalled response changed")

   `STBS_ASSERT_NOW(a_miss_index_zero, clock, reset, rsp_valid && !rsp_found,
      rsp_match_index == '0, "miss response carries a non-zero index")

   `STBS_ASSERT_NEXT(a_write_no_rsp, clock, reset,
      req_fire && (req_action == stbs_pkg::ACT_WRITE) && !rsp_valid,
      !rsp_valid, "table write produced a response")

   `STBS_ASSERT_NEXT(a_search_busy, clock, reset,
      req_fire && (req_action == stbs_pkg::ACT_SEARCH),
      !req_ready && !(rsp_valid && !$past(rsp_valid)),
      "search finished or took input in the cycle after acceptance")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
`default_nettype wire
